// ===== rtl/core/bufr_pkg.sv =====
`timescale 1ns / 1ps

package bufr_pkg;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned LenW       = 7;

  typedef enum logic [1:0] {
    CFG_DELIMITER = 2'd0,
    CFG_ESCAPE    = 2'd1,
    CFG_XOR_MASK  = 2'd2
  } cfg_index_t;

  // Frame store write port, front to back. addr[AddrW] selects the bank.
  typedef struct packed {
    logic             en;
    logic [AddrW:0]   addr;
    logic [7:0]       data;
  } store_wr_t;

  // One finished frame waiting to be sent out.
  typedef struct packed {
    logic             bank;
    logic [AddrW-1:0] len;
    logic [1:0]       kind;
  } frame_desc_t;

  typedef struct packed {
    logic [7:0] delimiter;
    logic [7:0] escape;
    logic [7:0] xor_mask;
  } cfg_t;

endpackage

// ===== rtl/core/bufr_front.sv =====
`timescale 1ns / 1ps

module bufr_front #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bufr_pkg::cfg_t         cfg,
  input  logic                   in_fire,
  input  logic                   packet_start,
  input  logic [15:0]            seq,
  input  logic                   has_byte,
  input  logic [7:0]             data_byte,
  output bufr_pkg::store_wr_t    store_wr,
  output logic                   q_push,
  output bufr_pkg::frame_desc_t  q_desc
);

  localparam int unsigned LenW = bufr_pkg::LenW;

  logic [15:0]     expected_seq, expected_seq_next;
  logic            in_sync, in_sync_next;
  logic            escape_pending, escape_pending_next;
  logic            frame_overflow, frame_overflow_next;
  logic [LenW-1:0] frame_length, frame_length_next;
  logic [1:0]      kind, kind_next;
  logic            wbank, wbank_next;

  logic            do_store;
  logic [7:0]      store_val;
  logic [LenW-1:0] wr_len;
  logic [LenW-1:0] len_inc;

  always_comb begin
    expected_seq_next   = expected_seq;
    in_sync_next        = in_sync;
    escape_pending_next = escape_pending;
    frame_overflow_next = frame_overflow;
    frame_length_next   = frame_length;
    kind_next           = kind;
    wbank_next          = wbank;
    do_store            = 1'b0;
    store_val           = data_byte;
    q_push              = 1'b0;

    if (packet_start) begin
      if (expected_seq + 16'd1 != seq) begin
        in_sync_next        = 1'b0;
        escape_pending_next = 1'b0;
        frame_overflow_next = 1'b0;
        frame_length_next   = '0;
      end
      expected_seq_next = seq;
    end

    if (has_byte) begin
      if (!in_sync_next) begin
        if (data_byte == cfg.delimiter) begin
          in_sync_next        = 1'b1;
          escape_pending_next = 1'b0;
          frame_overflow_next = 1'b0;
          frame_length_next   = '0;
        end
      end else if (data_byte == cfg.delimiter) begin
        if (frame_length_next != '0 || escape_pending_next) begin
          if (!frame_overflow_next && !escape_pending_next) begin
            q_push     = 1'b1;
            wbank_next = ~wbank;
          end
          escape_pending_next = 1'b0;
          frame_overflow_next = 1'b0;
          frame_length_next   = '0;
        end
      end else if (escape_pending_next) begin
        escape_pending_next = 1'b0;
        do_store            = 1'b1;
        store_val           = data_byte ^ cfg.xor_mask;
      end else if (data_byte == cfg.escape) begin
        if (!frame_overflow_next) begin
          escape_pending_next = 1'b1;
        end
      end else begin
        do_store = 1'b1;
      end
    end

    // Overflowed frames swallow further bytes.
    if (frame_overflow_next) begin
      do_store = 1'b0;
    end

    wr_len  = frame_length_next;
    len_inc = frame_length_next + LenW'(1);
    if (do_store) begin
      if (frame_length_next == '0) begin
        kind_next = store_val[7:6];
      end
      frame_length_next = len_inc;
      if (len_inc >= LenW'(MAX_PAYLOAD)) begin
        frame_overflow_next = 1'b1;
      end
    end
  end

  assign store_wr.en   = in_fire & do_store;
  assign store_wr.addr = {wbank, wr_len[bufr_pkg::AddrW-1:0]};
  assign store_wr.data = store_val;

  assign q_desc.bank = wbank;
  assign q_desc.len  = frame_length[bufr_pkg::AddrW-1:0];
  assign q_desc.kind = kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq   <= '0;
      in_sync        <= 1'b0;
      escape_pending <= 1'b0;
      frame_overflow <= 1'b0;
      frame_length   <= '0;
      kind           <= '0;
      wbank          <= 1'b0;
    end else if (in_fire) begin
      expected_seq   <= expected_seq_next;
      in_sync        <= in_sync_next;
      escape_pending <= escape_pending_next;
      frame_overflow <= frame_overflow_next;
      frame_length   <= frame_length_next;
      kind           <= kind_next;
      wbank          <= wbank_next;
    end
  end

endmodule

// ===== rtl/core/bufr_queue.sv =====
`timescale 1ns / 1ps

module bufr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  bufr_pkg::frame_desc_t  push_desc,
  input  logic                   pop,
  output logic                   head_valid,
  output bufr_pkg::frame_desc_t  head_desc,
  output logic                   full
);

  bufr_pkg::frame_desc_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head_desc  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("frame queue push while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("frame queue pop while empty");
  assert property (@(posedge clk) disable iff (rst) (full && !pop) |=> !push)
    else $error("frame queue accepted a frame with both banks busy");

endmodule

// ===== rtl/core/bufr_back.sv =====
`timescale 1ns / 1ps

module bufr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  bufr_pkg::store_wr_t    store_wr,
  input  logic                   head_valid,
  input  bufr_pkg::frame_desc_t  head_desc,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,  // payload_byte[7:0], byte_index[13:8]
  output logic [1:0]             m_tuser,  // frame_kind[1:0]
  output logic                   m_tlast
);

  localparam int unsigned AddrW = bufr_pkg::AddrW;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_SHOW  = 3'b100
  } state_t;

  logic [7:0]       mem [2*bufr_pkg::StoreDepth];
  logic [7:0]       rd_data;
  state_t           state, state_next;
  logic [AddrW-1:0] idx, idx_next;
  logic             is_last;

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.addr] <= store_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      rd_data <= mem[{head_desc.bank, idx}];
    end
  end

  assign is_last = (idx + AddrW'(1)) == head_desc.len;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    pop        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          idx_next   = '0;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (m_tready) begin
          if (is_last) begin
            pop        = 1'b1;
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + AddrW'(1);
            state_next = ST_FETCH;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  assign m_tvalid = (state == ST_SHOW);
  assign m_tdata  = {2'b00, idx, rd_data};
  assign m_tuser  = head_desc.kind;
  assign m_tlast  = is_last;

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (head_valid && (idx < head_desc.len)))
    else $error("result shown without a frame or past its length");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |=> (state == ST_SHOW))
    else $error("store read not followed by a result");

endmodule

// ===== rtl/core/byte_unstuffing_frame_receiver.sv =====
`timescale 1ns / 1ps
// With the back end idle, the closing delimiter's transaction registers the frame in the queue;
//   the back end picks it up in ST_IDLE, reads the store in ST_FETCH, raises m_tvalid in ST_SHOW.
// Output: each result is read from the store in ST_FETCH, then held in ST_SHOW until m_tready;
//   the next byte is not read before that, and the back end returns to ST_IDLE between frames.
// Throughput in: one item per cycle while a store bank is free; input stalls only while
//   two finished frames wait for the back end (two-bank frame store, two-entry queue).
// Reset (rst, synchronous): out of sync, empty frame, sequence 0, config to defaults 7E/7D/20.
//   The frame store is not cleared; only entries written for the current frame are read.

module byte_unstuffing_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // seq[15:0], data_byte[23:16]
  input  logic [1:0]  s_tuser,   // packet_start[0], has_byte[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // payload_byte[7:0], byte_index[13:8]
  output logic [1:0]  m_tuser,   // frame_kind[1:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  bufr_pkg::cfg_t         cfg;
  bufr_pkg::store_wr_t    store_wr;
  bufr_pkg::frame_desc_t  push_desc;
  bufr_pkg::frame_desc_t  head_desc;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   head_valid;
  logic                   in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter <= 8'h7E;
      cfg.escape    <= 8'h7D;
      cfg.xor_mask  <= 8'h20;
    end else if (cfg_we) begin
      case (cfg_index)
        bufr_pkg::CFG_DELIMITER: cfg.delimiter <= cfg_data;
        bufr_pkg::CFG_ESCAPE:    cfg.escape    <= cfg_data;
        bufr_pkg::CFG_XOR_MASK:  cfg.xor_mask  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold input while both banks hold frames not yet sent.
  assign s_tready = ~q_full;
  assign in_fire  = s_tvalid & s_tready;

  bufr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_fire      (in_fire),
    .packet_start (s_tuser[0]),
    .seq          (s_tdata[15:0]),
    .has_byte     (s_tuser[1]),
    .data_byte    (s_tdata[23:16]),
    .store_wr     (store_wr),
    .q_push       (q_push),
    .q_desc       (push_desc)
  );

  bufr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push & in_fire),
    .push_desc  (push_desc),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .full       (q_full)
  );

  bufr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .store_wr   (store_wr),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// ===== sim/deframe_checker.sv =====
`timescale 1ns / 1ps

module deframe_checker #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // seq[15:0], data_byte[23:16]
  input  logic [1:0]  s_tuser,   // packet_start[0], has_byte[1]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // payload_byte[7:0], byte_index[13:8]
  input  logic [1:0]  m_tuser,   // frame_kind[1:0]
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          pending,
  output int          mismatches
);

  typedef struct packed {
    logic [7:0] payload;
    logic [1:0] kind;
    logic [5:0] index;
    logic       last;
  } frame_byte_t;

  frame_byte_t    expected_bytes[$];
  frame_byte_t    want;
  bufr_pkg::cfg_t cfg;
  logic [15:0]    last_seq;
  logic           in_sync;
  logic           escape_pending;
  logic           overflow;
  logic [6:0]     frame_len;
  logic [7:0]     frame_bytes [bufr_pkg::StoreDepth];

  function automatic void drop_frame();
    escape_pending = 1'b0;
    overflow       = 1'b0;
    frame_len      = '0;
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    if (overflow) return;
    if (frame_len < bufr_pkg::StoreDepth) frame_bytes[frame_len[bufr_pkg::AddrW-1:0]] = b;
    frame_len = frame_len + 7'd1;
    if (frame_len >= MAX_PAYLOAD) overflow = 1'b1;
  endfunction

  task automatic unstuff_item(input logic start, input logic [15:0] seq,
                              input logic has, input logic [7:0] c);
    logic [15:0] next_seq;
    frame_byte_t fb;
    next_seq = last_seq + 16'd1;
    if (start) begin
      // a gap in the packet sequence loses sync and the frame in progress
      if (seq != next_seq) begin
        in_sync = 1'b0;
        drop_frame();
      end
      last_seq = seq;
    end
    if (!has) return;
    if (!in_sync) begin
      if (c == cfg.delimiter) begin
        in_sync = 1'b1;
        drop_frame();
      end
    end else if (c == cfg.delimiter) begin
      if (!overflow && !escape_pending && frame_len != 0) begin
        for (int i = 0; i < frame_len; i++) begin
          fb.payload = frame_bytes[i];
          fb.kind    = frame_bytes[0][7:6];
          fb.index   = 6'(i);
          fb.last    = (i == frame_len - 1);
          expected_bytes.push_back(fb);
        end
      end
      drop_frame();
    end else if (escape_pending) begin
      escape_pending = 1'b0;
      append_byte(c ^ cfg.xor_mask);
    end else if (c == cfg.escape) begin
      if (!overflow) escape_pending = 1'b1;
    end else begin
      append_byte(c);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg = '{delimiter: 8'h7E, escape: 8'h7D, xor_mask: 8'h20};
      last_seq = '0;
      in_sync  = 1'b0;
      drop_frame();
      expected_bytes.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bufr_pkg::CFG_DELIMITER: cfg.delimiter = cfg_data;
          bufr_pkg::CFG_ESCAPE:    cfg.escape    = cfg_data;
          bufr_pkg::CFG_XOR_MASK:  cfg.xor_mask  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        unstuff_item(s_tuser[0], s_tdata[15:0], s_tuser[1], s_tdata[23:16]);
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output transaction, payload_byte %0h", m_tdata[7:0]);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata[7:0] !== want.payload) begin
            $error("payload_byte: expected %0h, got %0h", want.payload, m_tdata[7:0]);
            mismatches++;
          end
          if (m_tuser !== want.kind) begin
            $error("frame_kind: expected %0d, got %0d", want.kind, m_tuser);
            mismatches++;
          end
          if (m_tdata[13:8] !== want.index) begin
            $error("byte_index: expected %0d, got %0d", want.index, m_tdata[13:8]);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            mismatches++;
          end
        end
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== sim/byte_unstuffing_frame_receiver_test.sv =====
`timescale 1ns / 1ps

module byte_unstuffing_frame_receiver_test;

  localparam int CycleLimit = 400000;
  localparam int HoldOffLen = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // seq[15:0], data_byte[23:16]
  logic [1:0]  s_tuser = '0;   // packet_start[0], has_byte[1]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // payload_byte[7:0], byte_index[13:8]
  logic [1:0]  m_tuser;        // frame_kind[1:0]
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = bufr_pkg::CFG_DELIMITER;
  logic [7:0]  cfg_data = '0;

  int pending;
  int mismatches;
  int cycle_count = 0;
  int items_sent = 0;

  bit          in_idle = 1'b0;
  bit          out_idle = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          seq_breaks = 1'b1;
  logic [15:0] link_seq = '0;
  logic [7:0]  delim = 8'h7E;
  logic [7:0]  esc = 8'h7D;
  logic [7:0]  mask = 8'h20;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  byte_unstuffing_frame_receiver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  deframe_checker frame_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .mismatches(mismatches)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic push_item(input logic start, input logic [15:0] seq,
                           input logic has, input logic [7:0] b);
    int gap;
    gap = in_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, seq};
    s_tuser  <= {has, start};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Wrap one raw byte into the packet stream: new packets, empty packets, sequence gaps.
  task automatic push_raw(input logic [7:0] b);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      link_seq = link_seq + 16'd1;
      push_item(1'b1, link_seq, 1'b0, 8'($urandom_range(0, 255)));
    end else if (r < 5) begin
      push_item(1'b0, 16'($urandom_range(0, 65535)), 1'b0, 8'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 199);
    if (seq_breaks && r < 3) begin
      link_seq = 16'($urandom_range(0, 65535));
      push_item(1'b1, link_seq, 1'b1, b);
    end else if (r < 28) begin
      link_seq = link_seq + 16'd1;
      push_item(1'b1, link_seq, 1'b1, b);
    end else begin
      push_item(1'b0, 16'($urandom_range(0, 65535)), 1'b1, b);
    end
  endtask

  task automatic push_frame(input int len, input bit dangle);
    logic [7:0] b;
    push_raw(delim);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       b = delim;
        1:       b = esc;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (b == delim || b == esc) begin
        push_raw(esc);
        push_raw(b ^ mask);
      end else begin
        push_raw(b);
      end
    end
    // leave an escape open so the closing delimiter drops the frame
    if (dangle) push_raw(esc);
    push_raw(delim);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic apply_config(input logic [7:0] d, input logic [7:0] e, input logic [7:0] m);
    delim = d;
    esc   = e;
    mask  = m;
    cfg_we    <= 1'b1;
    cfg_index <= bufr_pkg::CFG_DELIMITER;
    cfg_data  <= d;
    @(negedge clk);
    cfg_index <= bufr_pkg::CFG_ESCAPE;
    cfg_data  <= e;
    @(negedge clk);
    cfg_index <= bufr_pkg::CFG_XOR_MASK;
    cfg_data  <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver side: random stalls per transaction, one long hold-off on request.
  initial begin
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HoldOffLen) @(negedge clk);
        hold_off_req = 1'b0;
      end
      gap = out_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int r;
    int len;
    int phase_start;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    in_idle  = 1'b1;
    out_idle = 1'b1;
    push_item(1'b1, 16'h0001, 1'b0, 8'h00);   // empty packet, sequence in order
    push_item(1'b0, 16'hFFFF, 1'b1, 8'hFF);   // ignored while out of sync
    push_item(1'b0, 16'h0000, 1'b1, 8'h7E);   // gain sync
    push_item(1'b0, 16'h0000, 1'b1, 8'h7E);   // delimiter on an empty frame
    push_item(1'b1, 16'h0002, 1'b1, 8'hC0);
    push_item(1'b0, 16'hAAAA, 1'b1, 8'h7D);
    push_item(1'b0, 16'h5555, 1'b1, 8'h5E);   // escaped delimiter
    push_item(1'b0, 16'h0000, 1'b1, 8'h7D);
    push_item(1'b0, 16'h0000, 1'b1, 8'h5D);   // escaped escape
    push_item(1'b0, 16'h0000, 1'b1, 8'h00);
    push_item(1'b0, 16'h0000, 1'b1, 8'hFF);
    push_item(1'b0, 16'h0000, 1'b1, 8'h7E);   // close: five bytes out
    push_item(1'b0, 16'h0000, 1'b1, 8'h41);
    push_item(1'b0, 16'h0000, 1'b1, 8'h7D);
    push_item(1'b0, 16'h0000, 1'b1, 8'h7E);   // dangling escape drops the frame
    push_item(1'b0, 16'h0000, 1'b1, 8'h7D);
    push_item(1'b0, 16'h0000, 1'b1, 8'h7D);   // escape byte taken as data
    push_item(1'b0, 16'h0000, 1'b1, 8'h7E);
    push_item(1'b1, 16'h1234, 1'b1, 8'h80);   // sequence gap, byte ignored
    push_item(1'b1, 16'h1235, 1'b1, 8'h7E);
    push_item(1'b1, 16'h1236, 1'b1, 8'hBF);
    push_item(1'b0, 16'h0000, 1'b1, 8'h7E);
    link_seq = 16'h1236;

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0: apply_config(8'h7E, 8'h7D, 8'h20);
        1: apply_config(8'h00, 8'hFF, 8'hFF);
        2: apply_config(8'hFF, 8'h00, 8'h00);
        3: apply_config(8'h55, 8'h55, 8'hAA);   // delimiter and escape equal
        default: apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
      endcase
      if (ph == 0) begin
        in_idle  = 1'b0;
        out_idle = 1'b0;
        // longest frame, then one that overflows
        seq_breaks = 1'b0;
        push_frame(63, 1'b0);
        push_frame(64, 1'b0);
        seq_breaks = 1'b1;
      end else begin
        in_idle  = 1'($urandom_range(0, 1));
        out_idle = 1'($urandom_range(0, 1));
      end
      if (ph == 4) begin
        // keep offering frames while the receiver is held off
        in_idle      = 1'b0;
        hold_off_req = 1'b1;
      end
      phase_start = items_sent;
      while (items_sent - phase_start < 30) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          repeat ($urandom_range(1, 6))
            push_raw(($urandom_range(0, 4) == 0) ? delim : 8'($urandom_range(0, 255)));
        end else begin
          len = $urandom_range(0, 99);
          len = (len < 5)  ? 0 :
                (len < 82) ? $urandom_range(1, 8) :
                (len < 96) ? $urandom_range(9, 40) :
                (len < 98) ? 63 : $urandom_range(64, 66);
          push_frame(len, r >= 92);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
